// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the sample dump framer. Each macro samples on clk and
// is disabled while rst_n is low; both signals must be in scope at the use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/sdsf_pkg.sv
// ----------------------------------------------------------------------------
// sdsf_pkg
// Shared types and constants of the sample dump framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdsf_pkg;

  typedef enum logic [2:0] {
    OP_GENERAL = 3'd0,
    OP_REQUEST = 3'd1,
    OP_HEADER  = 3'd2,
    OP_LOAD    = 3'd3,
    OP_PACKET  = 3'd4,
    OP_TICK    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_GENERAL = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_HEADER  = 2'd2,
    KIND_DATA    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LEN  = 2'd1,
    ST_BUSY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_DEVICE_ID     = 3'd0,
    REG_SAMPLE_NUMBER = 3'd1,
    REG_SAMPLE_FORMAT = 3'd2,
    REG_SAMPLE_PERIOD = 3'd3,
    REG_SAMPLE_LENGTH = 3'd4,
    REG_LOOP_START    = 3'd5,
    REG_LOOP_END      = 3'd6,
    REG_LOOP_KIND     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_FETCH = 2'd1,
    S_EXEC  = 2'd2
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;   // input channel ready
    logic latch;  // capture the incoming request
    logic fetch;  // issue the buffer read for the held request
    logic exec;   // execute the held request and load the result register
  } sdsf_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;  // result register empty or drained this cycle
  } sdsf_stat_t;

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_NONRT = 8'h7E;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [7:0] SUB_HEADER  = 8'h01;
  localparam logic [7:0] SUB_PACKET  = 8'h02;
  localparam logic [7:0] SUB_REQUEST = 8'h03;

  localparam logic [6:0] LAST_GENERAL = 7'd5;
  localparam logic [6:0] LAST_REQUEST = 7'd6;
  localparam logic [6:0] LAST_HEADER  = 7'd20;

  localparam int CFG_WIDTH = 21;
  localparam int CFG_IDX_W = 3;

endpackage

// File: hw/rtl/sdsf_if.sv
// ----------------------------------------------------------------------------
// sdsf_if
// Valid/ready channels of the sample dump framer: request in, byte result out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sdsf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [6:0] msg_type;
  logic [6:0] packet_number;
  logic [6:0] buffer_index;
  logic [7:0] buffer_byte;
  logic [7:0] packet_length;

  modport source (output valid, opcode, msg_type, packet_number, buffer_index,
                  buffer_byte, packet_length, input ready);
  modport sink   (input valid, opcode, msg_type, packet_number, buffer_index,
                  buffer_byte, packet_length, output ready);
endinterface

interface sdsf_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] tx_byte;
  logic       message_end;
  logic [1:0] status;

  modport source (output valid, byte_valid, tx_byte, message_end, status,
                  input ready);
  modport sink   (input valid, byte_valid, tx_byte, message_end, status,
                  output ready);
endinterface

// File: hw/rtl/sdsf_ctrl.sv
// ----------------------------------------------------------------------------
// sdsf_ctrl
// Request sequencer: take a request, fetch the buffer byte, execute.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdsf_ctrl
  import sdsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  sdsf_stat_t stat,
  output sdsf_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_EXEC;
      S_EXEC:  if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.take  = 1'b1;
        cmd.latch = in_valid;
      end
      S_FETCH: cmd.fetch = 1'b1;
      S_EXEC:  cmd.exec  = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: hw/rtl/sdsf_dpath.sv
// ----------------------------------------------------------------------------
// sdsf_dpath
// Framer datapath: registers, packet buffer, message state and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdsf_dpath
  import sdsf_pkg::*;
#(
  parameter int PACKET_BYTES = 120
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sdsf_cmd_t            cmd,
  output sdsf_stat_t           stat,
  input  logic [2:0]           in_opcode,
  input  logic [6:0]           in_msg_type,
  input  logic [6:0]           in_packet_number,
  input  logic [6:0]           in_buffer_index,
  input  logic [7:0]           in_buffer_byte,
  input  logic [7:0]           in_packet_length,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_byte_valid,
  output logic [7:0]           out_tx_byte,
  output logic                 out_message_end,
  output logic [1:0]           out_status
);

  localparam int         AW        = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam logic [6:0] PB7       = 7'(PACKET_BYTES);
  localparam logic [7:0] PB8       = 8'(PACKET_BYTES);
  localparam logic [6:0] LAST_DATA = 7'(PACKET_BYTES + 6);

  // Configuration registers.
  logic [6:0]  dev_id_r, fmt_r, loop_kind_r;
  logic [13:0] sample_num_r;
  logic [20:0] period_r, length_r, loop_start_r, loop_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_id_r     <= '0;
      sample_num_r <= '0;
      fmt_r        <= '0;
      period_r     <= '0;
      length_r     <= '0;
      loop_start_r <= '0;
      loop_end_r   <= '0;
      loop_kind_r  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEVICE_ID:     dev_id_r     <= cfg_wdata[6:0];
        REG_SAMPLE_NUMBER: sample_num_r <= cfg_wdata[13:0];
        REG_SAMPLE_FORMAT: fmt_r        <= cfg_wdata[6:0];
        REG_SAMPLE_PERIOD: period_r     <= cfg_wdata;
        REG_SAMPLE_LENGTH: length_r     <= cfg_wdata;
        REG_LOOP_START:    loop_start_r <= cfg_wdata;
        REG_LOOP_END:      loop_end_r   <= cfg_wdata;
        REG_LOOP_KIND:     loop_kind_r  <= cfg_wdata[6:0];
        default:           dev_id_r     <= dev_id_r;
      endcase
    end
  end

  // Held request.
  logic [2:0] op_r;
  logic [6:0] req_type_r, req_pkt_r, req_idx_r;
  logic [7:0] req_byte_r, req_len_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r       <= in_opcode;
      req_type_r <= in_msg_type;
      req_pkt_r  <= in_packet_number;
      req_idx_r  <= in_buffer_index;
      req_byte_r <= in_buffer_byte;
      req_len_r  <= in_packet_length;
    end
  end

  // Message state.
  kind_t      kind_r, kind_nxt;
  logic       sending_r, sending_nxt;
  logic [6:0] pos_r, pos_nxt;
  logic [7:0] csum_r, csum_nxt;
  logic [6:0] held_type_r, held_type_nxt;
  logic [6:0] held_pkt_r, held_pkt_nxt;
  logic [6:0] held_len_r, held_len_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_GENERAL;
      sending_r   <= 1'b0;
      pos_r       <= '0;
      csum_r      <= '0;
      held_type_r <= '0;
      held_pkt_r  <= '0;
      held_len_r  <= '0;
    end else begin
      kind_r      <= kind_nxt;
      sending_r   <= sending_nxt;
      pos_r       <= pos_nxt;
      csum_r      <= csum_nxt;
      held_type_r <= held_type_nxt;
      held_pkt_r  <= held_pkt_nxt;
      held_len_r  <= held_len_nxt;
    end
  end

  // Packet buffer.
  logic [7:0]    mem [PACKET_BYTES];
  logic [7:0]    rd_data_r;
  logic [6:0]    data_off;
  logic          rd_ok;
  logic          mem_we;

  assign data_off = pos_r - 7'd5;
  assign rd_ok    = (data_off < PB7);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[req_idx_r[AW-1:0]] <= req_byte_r;
    end
    if (cmd.fetch && rd_ok) begin
      rd_data_r <= mem[data_off[AW-1:0]];
    end
  end

  // Byte at the current position.
  logic [6:0] last_pos;
  logic [7:0] cur_byte;

  always_comb begin
    unique case (kind_r)
      KIND_GENERAL: last_pos = LAST_GENERAL;
      KIND_REQUEST: last_pos = LAST_REQUEST;
      KIND_HEADER:  last_pos = LAST_HEADER;
      default:      last_pos = LAST_DATA;
    endcase
  end

  always_comb begin
    cur_byte = '0;
    priority if (pos_r == 7'd0) begin
      cur_byte = SYSEX_START;
    end else if (pos_r == 7'd1) begin
      cur_byte = SYSEX_NONRT;
    end else if (pos_r == 7'd2) begin
      cur_byte = {1'b0, dev_id_r};
    end else if (pos_r == last_pos) begin
      cur_byte = SYSEX_END;
    end else begin
      unique case (kind_r)
        KIND_GENERAL: begin
          cur_byte = (pos_r == 7'd3) ? {1'b0, held_type_r} : {1'b0, held_pkt_r};
        end
        KIND_REQUEST: begin
          unique case (pos_r)
            7'd3:    cur_byte = SUB_REQUEST;
            7'd4:    cur_byte = {1'b0, sample_num_r[6:0]};
            default: cur_byte = {1'b0, sample_num_r[13:7]};
          endcase
        end
        KIND_HEADER: begin
          unique case (pos_r)
            7'd3:    cur_byte = SUB_HEADER;
            7'd4:    cur_byte = {1'b0, sample_num_r[6:0]};
            7'd5:    cur_byte = {1'b0, sample_num_r[13:7]};
            7'd6:    cur_byte = {1'b0, fmt_r};
            7'd7:    cur_byte = {1'b0, period_r[6:0]};
            7'd8:    cur_byte = {1'b0, period_r[13:7]};
            7'd9:    cur_byte = {1'b0, period_r[20:14]};
            7'd10:   cur_byte = {1'b0, length_r[6:0]};
            7'd11:   cur_byte = {1'b0, length_r[13:7]};
            7'd12:   cur_byte = {1'b0, length_r[20:14]};
            7'd13:   cur_byte = {1'b0, loop_start_r[6:0]};
            7'd14:   cur_byte = {1'b0, loop_start_r[13:7]};
            7'd15:   cur_byte = {1'b0, loop_start_r[20:14]};
            7'd16:   cur_byte = {1'b0, loop_end_r[6:0]};
            7'd17:   cur_byte = {1'b0, loop_end_r[13:7]};
            7'd18:   cur_byte = {1'b0, loop_end_r[20:14]};
            default: cur_byte = {1'b0, loop_kind_r};
          endcase
        end
        default: begin
          priority if (pos_r == 7'd3) begin
            cur_byte = SUB_PACKET;
          end else if (pos_r == 7'd4) begin
            cur_byte = {1'b0, held_pkt_r};
          end else if (pos_r == last_pos - 7'd1) begin
            cur_byte = {1'b0, csum_r[6:0]};
          end else if (data_off < held_len_r && rd_ok) begin
            cur_byte = rd_data_r;
          end else begin
            cur_byte = '0;
          end
        end
      endcase
    end
  end

  // Execute and result register.
  logic       o_valid_r, o_valid_nxt;
  logic       o_bvalid_r, o_bvalid_nxt;
  logic [7:0] o_byte_r, o_byte_nxt;
  logic       o_end_r, o_end_nxt;
  status_t    o_status_r, o_status_nxt;

  assign stat.out_free = !o_valid_r || out_ready;

  always_comb begin
    kind_nxt      = kind_r;
    sending_nxt   = sending_r;
    pos_nxt       = pos_r;
    csum_nxt      = csum_r;
    held_type_nxt = held_type_r;
    held_pkt_nxt  = held_pkt_r;
    held_len_nxt  = held_len_r;
    mem_we        = 1'b0;
    o_valid_nxt   = o_valid_r && !out_ready;
    o_bvalid_nxt  = o_bvalid_r;
    o_byte_nxt    = o_byte_r;
    o_end_nxt     = o_end_r;
    o_status_nxt  = o_status_r;
    if (cmd.exec) begin
      o_valid_nxt  = 1'b1;
      o_bvalid_nxt = 1'b0;
      o_byte_nxt   = '0;
      o_end_nxt    = 1'b0;
      o_status_nxt = ST_OK;
      priority if (op_r <= OP_PACKET && sending_r) begin
        o_status_nxt = ST_BUSY;
      end else begin
        unique case (op_r)
          OP_GENERAL: begin
            held_type_nxt = req_type_r;
            held_pkt_nxt  = req_pkt_r;
            kind_nxt      = KIND_GENERAL;
            sending_nxt   = 1'b1;
            pos_nxt       = '0;
            csum_nxt      = '0;
          end
          OP_REQUEST, OP_HEADER: begin
            kind_nxt    = (op_r == OP_REQUEST) ? KIND_REQUEST : KIND_HEADER;
            sending_nxt = 1'b1;
            pos_nxt     = '0;
            csum_nxt    = '0;
          end
          OP_LOAD: begin
            mem_we = (req_idx_r < PB7);
          end
          OP_PACKET: begin
            if (req_len_r > PB8) begin
              o_status_nxt = ST_LEN;
            end else begin
              held_len_nxt = req_len_r[6:0];
              held_pkt_nxt = req_pkt_r;
              kind_nxt     = KIND_DATA;
              sending_nxt  = 1'b1;
              pos_nxt      = '0;
              csum_nxt     = '0;
            end
          end
          OP_TICK: begin
            if (sending_r) begin
              o_bvalid_nxt = 1'b1;
              o_byte_nxt   = cur_byte;
              if (kind_r == KIND_DATA && pos_r >= 7'd1 && pos_r < last_pos - 7'd1) begin
                csum_nxt = csum_r ^ cur_byte;
              end
              if (pos_r >= last_pos) begin
                o_end_nxt   = 1'b1;
                sending_nxt = 1'b0;
                pos_nxt     = '0;
              end else begin
                pos_nxt = pos_r + 7'd1;
              end
            end
          end
          default: o_status_nxt = ST_OK;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_bvalid_r <= o_bvalid_nxt;
    o_byte_r   <= o_byte_nxt;
    o_end_r    <= o_end_nxt;
    o_status_r <= o_status_nxt;
  end

  assign out_valid       = o_valid_r;
  assign out_byte_valid  = o_bvalid_r;
  assign out_tx_byte     = o_byte_r;
  assign out_message_end = o_end_r;
  assign out_status      = o_status_r;

endmodule

// File: hw/rtl/sds_message_framer.sv
// ----------------------------------------------------------------------------
// sds_message_framer
// Frames sample dump system-exclusive messages into a byte stream.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake        Carries
// in_ch     in   valid/ready      opcode, msg_type, packet_number, buffer_index,
//                                 buffer_byte, packet_length
// out_ch    out  valid/ready      byte_valid, tx_byte, message_end, status
// cfg_*     in   write enable     cfg_index selects one of eight registers
//
// Each request passes through take, buffer read and execute. The buffer
// read of the packet store is registered, which is why it has a step of its own.
// A new request is taken while the previous result still waits in the output
// register; execution holds when that register is still full.
// Reset is synchronous and active low; the packet store has no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sds_message_framer
  import sdsf_pkg::*;
#(
  parameter int PACKET_BYTES = 120
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sdsf_in_if.sink              in_ch,
  sdsf_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_wdata
);

  sdsf_cmd_t  cmd;
  sdsf_stat_t stat;

  // Take requests only while the sequencer is idle.
  assign in_ch.ready = cmd.take;

  sdsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath holds the registers, the packet store and the result register.
  sdsf_dpath #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_ch.opcode),
    .in_msg_type      (in_ch.msg_type),
    .in_packet_number (in_ch.packet_number),
    .in_buffer_index  (in_ch.buffer_index),
    .in_buffer_byte   (in_ch.buffer_byte),
    .in_packet_length (in_ch.packet_length),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_byte_valid   (out_ch.byte_valid),
    .out_tx_byte      (out_ch.tx_byte),
    .out_message_end  (out_ch.message_end),
    .out_status       (out_ch.status)
  );

  // A taken request always moves on to its buffer read.
  `ASSERT_NEXT(a_take_then_fetch, in_ch.valid && in_ch.ready, cmd.fetch)
  // Never overwrite a result that is still waiting.
  `ASSERT_IMPLIES(a_exec_free, cmd.exec, !out_ch.valid || out_ch.ready)
  // The end flag rides only on a valid end-of-exclusive byte.
  `ASSERT_IMPLIES(a_end_byte, out_ch.valid && out_ch.message_end,
                  out_ch.byte_valid && out_ch.tx_byte == SYSEX_END)

endmodule
